>>> rtl/tee_pkg.sv
// Package with the shared types and byte constants of the truecolor escape encoder.
`timescale 1ns / 1ps
`default_nettype none

package tee_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Input item kinds; code 3 carries no meaning and is dropped.
  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_HOME  = 2'd1,
    KIND_HUD   = 2'd2
  } tee_kind_e;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    OP_HOME  = 2'd0,
    OP_GLYPH = 2'd1,
    OP_COLOR = 2'd2
  } tee_op_e;

  // Segments of the output sequence walked by the back.
  typedef enum logic [2:0] {
    SEG_PREFIX = 3'd0,
    SEG_RED    = 3'd1,
    SEG_GREEN  = 3'd2,
    SEG_BLUE   = 3'd3,
    SEG_GLYPH  = 3'd4,
    SEG_HOME   = 3'd5
  } tee_seg_e;

  // Decimal form of one component: digits left aligned, cnt digits in use (1 to 3).
  typedef struct packed {
    logic [1:0] cnt;
    logic [3:0] d0;
    logic [3:0] d1;
    logic [3:0] d2;
  } tee_dec_t;

  typedef struct packed {
    tee_op_e  op;
    tee_dec_t red;
    tee_dec_t green;
    tee_dec_t blue;
  } tee_cmd_t;

  localparam logic [7:0] ESC_BYTE    = 8'h1B;
  localparam logic [7:0] WHITE_LEVEL = 8'd255;
  localparam logic [7:0] MASK_RESET  = 8'd255;
  localparam logic [7:0] SEMI_BYTE   = 8'h3B;
  localparam logic [7:0] M_BYTE      = 8'h6D;
  localparam logic [3:0] DIGIT_HIGH  = 4'h3;

  localparam int unsigned PREFIX_LEN = 7;
  localparam int unsigned TRIPLE_LEN = 3;

  localparam logic [7:0] PREFIX_BYTES [PREFIX_LEN] =
    '{ESC_BYTE, 8'h5B, 8'h33, 8'h38, SEMI_BYTE, 8'h32, SEMI_BYTE};
  localparam logic [7:0] GLYPH_BYTES [TRIPLE_LEN] = '{8'hE2, 8'h96, 8'h88};
  localparam logic [7:0] HOME_BYTES  [TRIPLE_LEN] = '{ESC_BYTE, 8'h5B, 8'h48};

endpackage

`default_nettype wire

>>> rtl/tee_if.sv
// Channel interfaces of the truecolor escape encoder: pixel input, byte output, configuration.
`timescale 1ns / 1ps
`default_nettype none

interface tee_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, kind, red, green, blue, input ready);
  modport sink   (input valid, kind, red, green, blue, output ready);
endinterface

interface tee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

interface tee_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/tee_front.sv
// Front end: takes items, masks and compares colours with the cache, queues byte work.
`timescale 1ns / 1ps
`default_nettype none

module tee_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  tee_in_if.sink                 in_i,
  tee_cfg_if.sink                cfg_i,
  input  wire logic              q_full_i,
  output      logic              q_push_o,
  output      tee_pkg::tee_cmd_t q_cmd_o
);
  import tee_pkg::*;

  logic [7:0] mask_q;
  logic [7:0] red_q, red_d;
  logic [7:0] green_q, green_d;
  logic [7:0] blue_q, blue_d;
  logic [7:0] red_m, green_m, blue_m;
  logic       accept;
  logic       changed;

  // Hundreds by comparison, tens by multiplying with 205/2048, which is exact below 1029.
  function automatic tee_dec_t to_dec(input logic [7:0] v);
    logic [1:0]  h;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens10;
    logic [3:0]  ones;
    tee_dec_t    res;
    if (v >= 8'd200) begin
      h   = 2'd2;
      rem = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      h   = 2'd1;
      rem = 7'(v - 8'd100);
    end else begin
      h   = 2'd0;
      rem = v[6:0];
    end
    prod   = 15'(rem) * 15'd205;
    tens   = prod[14:11];
    tens10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    ones   = 4'(rem - tens10);
    if (h != 2'd0) begin
      res = '{cnt: 2'd3, d0: {2'b00, h}, d1: tens, d2: ones};
    end else if (tens != 4'd0) begin
      res = '{cnt: 2'd2, d0: tens, d1: ones, d2: 4'd0};
    end else begin
      res = '{cnt: 2'd1, d0: ones, d1: 4'd0, d2: 4'd0};
    end
    return res;
  endfunction

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !q_full_i;
  assign accept      = in_i.valid && in_i.ready;

  assign red_m   = in_i.red & mask_q;
  assign green_m = in_i.green & mask_q;
  assign blue_m  = in_i.blue & mask_q;
  assign changed = (red_m != red_q) || (green_m != green_q) || (blue_m != blue_q);

  always_comb begin
    red_d         = red_q;
    green_d       = green_q;
    blue_d        = blue_q;
    q_push_o      = 1'b0;
    q_cmd_o.op    = OP_HOME;
    q_cmd_o.red   = to_dec(red_m);
    q_cmd_o.green = to_dec(green_m);
    q_cmd_o.blue  = to_dec(blue_m);
    unique case (in_i.kind)
      KIND_PIXEL: begin
        q_push_o   = accept;
        q_cmd_o.op = changed ? OP_COLOR : OP_GLYPH;
        if (accept) begin
          red_d   = red_m;
          green_d = green_m;
          blue_d  = blue_m;
        end
      end
      KIND_HOME: begin
        q_push_o = accept;
      end
      KIND_HUD: begin
        if (accept) begin
          red_d   = WHITE_LEVEL;
          green_d = WHITE_LEVEL;
          blue_d  = WHITE_LEVEL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= MASK_RESET;
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
    end else begin
      if (cfg_i.valid) begin
        mask_q <= cfg_i.data;
      end
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tee_queue.sv
// Short queue of byte work between the front end and the byte sequencer.
`timescale 1ns / 1ps
`default_nettype none

module tee_queue #(
  parameter int unsigned Depth = tee_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  tee_pkg::tee_cmd_t      cmd_i,
  output      logic              full_o,
  output      logic              valid_o,
  output      tee_pkg::tee_cmd_t cmd_o,
  input  wire logic              pop_i
);
  import tee_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tee_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tee_back.sv
// Byte sequencer: escape, digits and glyph, or home bytes, of an item, one byte per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module tee_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  tee_pkg::tee_cmd_t q_cmd_i,
  output      logic         q_pop_o,
  tee_out_if.source         out_o
);
  import tee_pkg::*;

  localparam logic [2:0] PrefixEnd = 3'(PREFIX_LEN - 1);
  localparam logic [2:0] TripleEnd = 3'(TRIPLE_LEN - 1);

  tee_seg_e   seg_q, seg_d;
  logic [2:0] idx_q, idx_d;
  logic       busy_q, busy_d;
  tee_cmd_t   cmd_q, cmd_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;

  tee_dec_t   cur_dec;
  logic [3:0] digit;
  logic [7:0] byte_val;
  logic       seg_end;
  logic       byte_last;
  tee_seg_e   seg_next;
  logic       adv;
  logic       fin;

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last     = out_last_q;

  // While an item is in progress, a byte is made whenever the output register is free or is being emptied.
  assign adv     = busy_q && (!out_valid_q || out_o.ready);
  assign fin     = adv && byte_last;
  assign q_pop_o = q_valid_i && (!busy_q || fin);

  always_comb begin
    cur_dec = cmd_q.red;
    if (seg_q == SEG_GREEN) begin
      cur_dec = cmd_q.green;
    end else if (seg_q == SEG_BLUE) begin
      cur_dec = cmd_q.blue;
    end
    unique case (idx_q[1:0])
      2'd0:    digit = cur_dec.d0;
      2'd1:    digit = cur_dec.d1;
      default: digit = cur_dec.d2;
    endcase
  end

  always_comb begin
    byte_val  = PREFIX_BYTES[idx_q];
    seg_end   = 1'b0;
    byte_last = 1'b0;
    seg_next  = seg_q;
    unique case (seg_q)
      SEG_PREFIX: begin
        byte_val = PREFIX_BYTES[idx_q];
        seg_end  = (idx_q == PrefixEnd);
        seg_next = SEG_RED;
      end
      SEG_RED, SEG_GREEN, SEG_BLUE: begin
        // After the digits comes a separator, or the closing m after blue.
        if (idx_q == {1'b0, cur_dec.cnt}) begin
          byte_val = (seg_q == SEG_BLUE) ? M_BYTE : SEMI_BYTE;
          seg_end  = 1'b1;
        end else begin
          byte_val = {DIGIT_HIGH, digit};
        end
        if (seg_q == SEG_RED) begin
          seg_next = SEG_GREEN;
        end else if (seg_q == SEG_GREEN) begin
          seg_next = SEG_BLUE;
        end else begin
          seg_next = SEG_GLYPH;
        end
      end
      SEG_GLYPH: begin
        byte_val  = GLYPH_BYTES[idx_q[1:0]];
        seg_end   = (idx_q == TripleEnd);
        byte_last = seg_end;
      end
      SEG_HOME: begin
        byte_val  = HOME_BYTES[idx_q[1:0]];
        seg_end   = (idx_q == TripleEnd);
        byte_last = seg_end;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    seg_d       = seg_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (q_pop_o) begin
      busy_d = 1'b1;
      cmd_d  = q_cmd_i;
      idx_d  = '0;
      unique case (q_cmd_i.op)
        OP_COLOR: seg_d = SEG_PREFIX;
        OP_GLYPH: seg_d = SEG_GLYPH;
        OP_HOME:  seg_d = SEG_HOME;
        default:  seg_d = SEG_HOME;
      endcase
    end else if (fin) begin
      busy_d = 1'b0;
    end else if (adv) begin
      if (seg_end) begin
        seg_d = seg_next;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end

    if (adv) begin
      out_valid_d = 1'b1;
      out_byte_d  = byte_val;
      out_last_d  = byte_last;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      seg_q       <= SEG_HOME;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      seg_q       <= seg_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

endmodule

`default_nettype wire

>>> rtl/truecolor_escape_encoder_top.sv
// Top level of the truecolor escape encoder: front end, work queue and byte sequencer.
//
// Pixels, cursor-home and hud-written items enter on in_i; terminal bytes leave on out_o,
// one byte per cycle unless out_o stalls, with last set on the final byte of each item.
// A pixel whose masked colour matches the cached colour gives 3 bytes (the full-block
// glyph); a changed colour gives 16 to 22 bytes (ESC [ 3 8 ; 2 ; R ; G ; B m, then the
// glyph); cursor home gives 3 bytes; hud-written and unused kinds give none. The byte
// sequencer sets the throughput: the bytes of an item leave back to back with those of
// the next. The front end takes a new item whenever the work queue has room, so a few
// items are absorbed while the output stalls. color_mask must be written by the user on
// cfg_i only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module truecolor_escape_encoder_top #(
  parameter int unsigned QueueDepth = tee_pkg::QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tee_in_if.sink    in_i,
  tee_cfg_if.sink   cfg_i,
  tee_out_if.source out_o
);
  import tee_pkg::*;

  logic     q_full;
  logic     q_push;
  tee_cmd_t q_cmd_in;
  logic     q_valid;
  tee_cmd_t q_cmd_out;
  logic     q_pop;

  tee_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_cmd_in)
  );

  tee_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out),
    .pop_i   (q_pop)
  );

  tee_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd_out),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire
